// ----- design/kda_pkg.sv -----
// Shared types and constants for the keypad debounce / auto-repeat block.
// No dependencies; kda_front, kda_queue, kda_back and the core import this package.
package kda_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIndexW-1:0] RegRepeatMask       = 3'd0;
  localparam logic [CfgIndexW-1:0] RegRepeatTicks      = 3'd1;
  localparam logic [CfgIndexW-1:0] RegConfirmTicks     = 3'd2;
  localparam logic [CfgIndexW-1:0] RegReleasePollTicks = 3'd3;
  localparam logic [CfgIndexW-1:0] RegLongPauseTicks   = 3'd4;

  // Register reset values
  localparam logic [15:0] RepeatMaskReset       = 16'd0;
  localparam logic [7:0]  RepeatTicksReset      = 8'd100;
  localparam logic [7:0]  ConfirmTicksReset     = 8'd1;
  localparam logic [7:0]  ReleasePollTicksReset = 8'd1;
  localparam logic [7:0]  LongPauseTicksReset   = 8'd200;

  // Item opcodes
  localparam logic OpTick = 1'b0;
  localparam logic OpEdge = 1'b1;

  // Event kinds
  localparam logic [1:0] EvPress = 2'd0;
  localparam logic [1:0] EvKeyUp = 2'd1;
  localparam logic [1:0] EvLong  = 2'd2;

  localparam int QueueDepthDefault = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] code;
  } kda_result_t;

  // All events caused by one item: one, or two when 'two' is set
  typedef struct packed {
    logic        two;
    kda_result_t first;
    kda_result_t second;
  } kda_bundle_t;

endpackage

// ----- design/kda_keys_if.sv -----
// Input channel of the keypad block: opcode plus sensed row/column lines.
// No dependencies.
interface kda_keys_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] row_lines;
  logic [3:0] col_lines;

  modport source (output valid, output op, output row_lines, output col_lines, input ready);
  modport sink   (input valid, input op, input row_lines, input col_lines, output ready);
endinterface

// ----- design/kda_events_if.sv -----
// Output channel of the keypad block: one event word per handshake.
// No dependencies.
interface kda_events_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [3:0] key_code;
  logic       last;

  modport source (output valid, output event_kind, output key_code, output last, input ready);
  modport sink   (input valid, input event_kind, input key_code, input last, output ready);
endinterface

// ----- design/kda_front.sv -----
// Front end: config registers, key decode and both state machines.
// Depends on kda_pkg and kda_keys_if; pushes event bundles into the queue.
module kda_front (
  input  logic                           clk,
  input  logic                           rst,
  kda_keys_if.sink                       keys,
  input  logic                           cfg_we,
  input  logic [kda_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [kda_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                           q_ready,
  output logic                           push,
  output kda_pkg::kda_bundle_t           bundle
);
  import kda_pkg::*;

  typedef enum logic [2:0] {
    PS_IDLE, PS_DOWN_START, PS_DOWN_END, PS_UP_START, PS_UP_END, PS_LONG_PAUSE
  } press_state_t;

  typedef enum logic [1:0] {RS_IDLE, RS_START, RS_END} repeat_state_t;

  function automatic logic [4:0] decode_key(input logic [3:0] rows, input logic [3:0] cols);
    logic [2:0] nr;
    logic [2:0] nc;
    logic [1:0] r;
    logic [1:0] c;
    nr = '0;
    nc = '0;
    r  = '0;
    c  = '0;
    for (int i = 0; i < 4; i++) begin
      if (!rows[i]) begin
        nr = nr + 3'd1;
        r  = 2'(i);
      end
      if (!cols[i]) begin
        nc = nc + 3'd1;
        c  = 2'(i);
      end
    end
    return (nr == 3'd1 && nc == 3'd1) ? {1'b1, r, c} : 5'd0;
  endfunction

  logic [15:0] repeat_mask;
  logic [7:0]  repeat_ticks, confirm_ticks, release_poll_ticks, long_pause_ticks;

  press_state_t  press_fsm, press_fsm_next;
  repeat_state_t repeat_fsm, repeat_fsm_next;
  logic [7:0]    press_count, press_count_next, repeat_count, repeat_count_next;
  logic [7:0]    press_limit, press_limit_next, repeat_limit, repeat_limit_next;
  logic [4:0]    held_key, held_key_next;   // {valid, code}; none is all zero

  logic        accept;
  logic [4:0]  key;
  logic [7:0]  pc_inc, rc_inc;
  logic        emit_p, emit_r;
  kda_result_t res_p, res_r;

  assign keys.ready = q_ready;
  assign accept     = keys.valid && keys.ready;
  assign key        = decode_key(keys.row_lines, keys.col_lines);
  assign pc_inc     = (press_count == 8'hFF) ? press_count : press_count + 8'd1;
  assign rc_inc     = (repeat_count == 8'hFF) ? repeat_count : repeat_count + 8'd1;

  always_comb begin
    press_fsm_next    = press_fsm;
    repeat_fsm_next   = repeat_fsm;
    press_count_next  = press_count;
    repeat_count_next = repeat_count;
    press_limit_next  = press_limit;
    repeat_limit_next = repeat_limit;
    held_key_next     = held_key;
    emit_p            = 1'b0;
    emit_r            = 1'b0;
    res_p             = '0;
    res_r             = '0;
    if (keys.op == OpEdge) begin
      if (press_fsm == PS_IDLE || press_fsm == PS_LONG_PAUSE) begin
        press_fsm_next   = PS_DOWN_START;
        press_count_next = '0;
        press_limit_next = confirm_ticks;
      end
    end else if (press_fsm != PS_IDLE) begin
      press_count_next  = pc_inc;
      repeat_count_next = rc_inc;
      if (pc_inc >= press_limit) begin
        press_count_next = '0;
        unique case (press_fsm)
          PS_DOWN_START: begin
            if (key[4]) begin
              held_key_next    = key;
              press_fsm_next   = PS_DOWN_END;
              press_limit_next = confirm_ticks;
            end else begin
              press_fsm_next = PS_IDLE;
            end
          end
          PS_DOWN_END: begin
            if (key[4] && key == held_key) begin
              emit_p = 1'b1;
              res_p  = '{kind: EvPress, code: held_key[3:0]};
              if (repeat_mask[held_key[3:0]]) begin
                repeat_fsm_next   = RS_START;
                repeat_count_next = '0;
                repeat_limit_next = repeat_ticks;
              end
              press_fsm_next   = PS_UP_START;
              press_limit_next = release_poll_ticks;
            end else begin
              press_fsm_next = PS_IDLE;
            end
          end
          PS_UP_START: begin
            if (!key[4]) begin
              press_fsm_next   = PS_UP_END;
              press_limit_next = confirm_ticks;
            end else begin
              press_limit_next = release_poll_ticks;
            end
          end
          PS_UP_END: begin
            if (!key[4]) begin
              emit_p           = 1'b1;
              res_p            = '{kind: EvKeyUp, code: 4'd0};
              held_key_next    = '0;
              repeat_fsm_next  = RS_IDLE;
              press_fsm_next   = PS_LONG_PAUSE;
              press_limit_next = long_pause_ticks;
            end else begin
              press_fsm_next   = PS_UP_START;
              press_limit_next = release_poll_ticks;
            end
          end
          PS_LONG_PAUSE: begin
            emit_p         = 1'b1;
            res_p          = '{kind: EvLong, code: 4'd0};
            press_fsm_next = PS_IDLE;
          end
          default: press_fsm_next = PS_IDLE;
        endcase
      end
      // Repeat machine sees what the press machine left this tick
      if (repeat_fsm_next != RS_IDLE && repeat_count_next >= repeat_limit_next) begin
        repeat_count_next = '0;
        if (key == held_key_next) begin
          if (repeat_fsm_next == RS_START) begin
            repeat_fsm_next   = RS_END;
            repeat_limit_next = confirm_ticks;
          end else begin
            emit_r            = 1'b1;
            res_r             = '{kind: EvPress, code: held_key_next[3:0]};
            repeat_fsm_next   = RS_START;
            repeat_limit_next = repeat_ticks;
          end
        end else begin
          repeat_fsm_next = RS_IDLE;
        end
      end
    end
  end

  assign push          = accept && (emit_p || emit_r);
  assign bundle.two    = emit_p && emit_r;
  assign bundle.first  = emit_p ? res_p : res_r;
  assign bundle.second = res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_mask        <= RepeatMaskReset;
      repeat_ticks       <= RepeatTicksReset;
      confirm_ticks      <= ConfirmTicksReset;
      release_poll_ticks <= ReleasePollTicksReset;
      long_pause_ticks   <= LongPauseTicksReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRepeatMask:       repeat_mask        <= cfg_data;
        RegRepeatTicks:      repeat_ticks       <= cfg_data[7:0];
        RegConfirmTicks:     confirm_ticks      <= cfg_data[7:0];
        RegReleasePollTicks: release_poll_ticks <= cfg_data[7:0];
        RegLongPauseTicks:   long_pause_ticks   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_fsm    <= PS_IDLE;
      repeat_fsm   <= RS_IDLE;
      press_count  <= '0;
      repeat_count <= '0;
      press_limit  <= '0;
      repeat_limit <= '0;
      held_key     <= '0;
    end else if (accept) begin
      press_fsm    <= press_fsm_next;
      repeat_fsm   <= repeat_fsm_next;
      press_count  <= press_count_next;
      repeat_count <= repeat_count_next;
      press_limit  <= press_limit_next;
      repeat_limit <= repeat_limit_next;
      held_key     <= held_key_next;
    end
  end

  // A running repeat always tracks a confirmed key
  a_repeat_has_key: assert property (@(posedge clk) disable iff (rst)
    repeat_fsm != RS_IDLE |-> held_key[4])
    else $error("repeat machine active without a held key");

  // Between press confirm and key-up the held key stays valid
  a_held_in_press: assert property (@(posedge clk) disable iff (rst)
    (press_fsm == PS_DOWN_END || press_fsm == PS_UP_START || press_fsm == PS_UP_END)
      |-> held_key[4])
    else $error("press machine past decode without a held key");

endmodule

// ----- design/kda_queue.sv -----
// Short FIFO of event bundles between the front end and the output stage.
// Depends on kda_pkg.
module kda_queue #(
  parameter int Depth = kda_pkg::QueueDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  kda_pkg::kda_bundle_t  push_bundle,
  output logic                  ready,
  output logic                  q_valid,
  output kda_pkg::kda_bundle_t  q_bundle,
  input  logic                  pop
);
  import kda_pkg::*;

  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  kda_bundle_t       slots [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CountW-1:0] count;
  logic              full;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full     = (count == CountW'(Depth));
  assign ready    = !full;
  assign q_valid  = (count != '0);
  assign q_bundle = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= advance(wr_ptr);
      if (pop)  rd_ptr <= advance(rd_ptr);
      if (push && !pop)      count <= count + CountW'(1);
      else if (pop && !push) count <= count - CountW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("bundle pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !q_valid))
    else $error("bundle popped from empty queue");

endmodule

// ----- design/kda_back.sv -----
// Output stage: splits each bundle into event words behind an output register.
// Depends on kda_pkg and kda_events_if.
module kda_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  kda_pkg::kda_bundle_t  q_bundle,
  output logic                  pop,
  kda_events_if.source          events
);
  import kda_pkg::*;

  logic        out_valid;
  kda_result_t out_res;
  logic        out_last;
  logic        pend_valid;   // second event of a bundle still to send
  kda_result_t pend_res;
  logic        load;

  assign load = !out_valid || events.ready;
  assign pop  = load && !pend_valid && q_valid;

  assign events.valid      = out_valid;
  assign events.event_kind = out_res.kind;
  assign events.key_code   = out_res.code;
  assign events.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= q_valid;
        pend_valid <= q_valid && q_bundle.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_res  <= pend_res;
        out_last <= 1'b1;
      end else begin
        out_res  <= q_bundle.first;
        out_last <= !q_bundle.two;
        pend_res <= q_bundle.second;
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid && !out_last)
    else $error("second event pending without its first in the output register");

endmodule

// ----- design/keypad_debounce_autorepeat_core.sv -----
// 4x4 keypad qualifier with debounce and auto-repeat. Each word on 'keys' is a
// timer tick or a key-line falling edge with the sensed active-low row and
// column lines; a key decodes only when exactly one row and one column are
// low (code = row*4 + col). The front end updates both state machines in
// the cycle a word is accepted, so a word can be taken every cycle while the
// queue has room. Its events (press/repeat, key-up, long pause; at most two,
// the final one flagged with 'last') reach 'events' through the queue slot
// register and then the output register, which sends one event word a
// cycle while 'events' is ready; a tick that yields two events holds the
// output for both words. A queue of QueueDepth bundles absorbs that and any
// output stall, and 'keys' stalls only while the queue is full. Write
// configuration (cfg_we, cfg_index, cfg_data) only while the block is idle.
module keypad_debounce_autorepeat_core #(
  parameter int QueueDepth = kda_pkg::QueueDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  kda_keys_if.sink                       keys,
  kda_events_if.source                   events,
  input  logic                           cfg_we,
  input  logic [kda_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [kda_pkg::CfgDataW-1:0]   cfg_data
);
  import kda_pkg::*;

  logic        push;
  logic        q_ready;
  logic        q_valid;
  logic        pop;
  kda_bundle_t push_bundle;
  kda_bundle_t q_bundle;

  // Decode, debounce and repeat timing; one bundle per word with events
  kda_front u_front (
    .clk       (clk),
    .rst       (rst),
    .keys      (keys),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_ready   (q_ready),
    .push      (push),
    .bundle    (push_bundle)
  );

  // Decouple the front end from output back-pressure
  kda_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .ready       (q_ready),
    .q_valid     (q_valid),
    .q_bundle    (q_bundle),
    .pop         (pop)
  );

  // Serialize bundles into event words
  kda_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_bundle (q_bundle),
    .pop      (pop),
    .events   (events)
  );

endmodule
